// ===== rtl/z80_register_alu_executor_unit_assert.svh =====
// assertion macros shared by the z80 alu executor rtl
`ifndef Z80_REGISTER_ALU_EXECUTOR_UNIT_ASSERT_SVH
`define Z80_REGISTER_ALU_EXECUTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define Z80ALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define Z80ALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/z80alu_pkg.sv =====
// types, codes and helper functions for the z80 alu executor
`timescale 1ns / 1ps

package z80alu_pkg;

  // input item
  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] immediate;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0]  accumulator;
    logic [7:0]  flags;
    logic        dest_valid;
    logic [2:0]  dest_index;
    logic [7:0]  dest_value;
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        halted;
  } out_item_t;

  // architectural registers
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] e;
    logic [7:0] h;
    logic [7:0] l;
    logic [7:0] a;
  } regfile_t;

  // opcode groups, bits 7:6
  typedef enum logic [1:0] {
    GRP_MISC  = 2'd0,
    GRP_LOAD  = 2'd1,
    GRP_ALU   = 2'd2,
    GRP_OTHER = 2'd3
  } op_grp_t;

  // alu operations, bits 5:3 of the alu group
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_SBC = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_OR  = 3'd6;
  localparam logic [2:0] ALU_CP  = 3'd7;

  // register codes
  localparam logic [2:0] REG_B      = 3'd0;
  localparam logic [2:0] REG_C      = 3'd1;
  localparam logic [2:0] REG_D      = 3'd2;
  localparam logic [2:0] REG_E      = 3'd3;
  localparam logic [2:0] REG_H      = 3'd4;
  localparam logic [2:0] REG_L      = 3'd5;
  localparam logic [2:0] REG_HL_MEM = 3'd6;
  localparam logic [2:0] REG_A      = 3'd7;

  // low-field codes of the misc group
  localparam logic [2:0] Z_INC = 3'd4;
  localparam logic [2:0] Z_DEC = 3'd5;
  localparam logic [2:0] Z_IMM = 3'd6;

  // flag bit positions
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_H  = 4;
  localparam int FLAG_PV = 2;
  localparam int FLAG_N  = 1;
  localparam int FLAG_C  = 0;

  // boundary values for inc and dec overflow
  localparam logic [7:0] INC_OVF_VAL = 8'h7F;
  localparam logic [7:0] DEC_OVF_VAL = 8'h80;

  // register read by code; the memory operand code reads as zero
  function automatic logic [7:0] rf_read(regfile_t rf, logic [2:0] code);
    logic [7:0] val;
    case (code)
      REG_B:   val = rf.b;
      REG_C:   val = rf.c;
      REG_D:   val = rf.d;
      REG_E:   val = rf.e;
      REG_H:   val = rf.h;
      REG_L:   val = rf.l;
      REG_A:   val = rf.a;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // assemble a flag byte, bits 5 and 3 always clear
  function automatic logic [7:0] mk_flags(logic [7:0] res, logic h, logic pv, logic n,
                                          logic c);
    logic [7:0] f;
    f          = 8'h00;
    f[FLAG_S]  = res[7];
    f[FLAG_Z]  = (res == 8'h00);
    f[FLAG_H]  = h;
    f[FLAG_PV] = pv;
    f[FLAG_N]  = n;
    f[FLAG_C]  = c;
    return f;
  endfunction

endpackage

// ===== rtl/z80_register_alu_executor_unit.sv =====
// top level of the z80 register alu executor
`timescale 1ns / 1ps

// Executes one Z80 instruction byte per item against internal B,C,D,E,H,L,A
// registers and a flag byte, returning one result item per input item in
// order. Each result is registered, so one item per cycle is sustained while
// in_ready is high; that figure is set by the loop through the register file,
// since each instruction reads the registers that the previous one wrote.
// The result register is backed by a one-entry skid stage, so in_ready
// stays high while a result waits and drops only when both hold results
// that out_ready has not taken. Operand forms that use (HL), ADC, SBC and
// all unlisted opcodes leave the state unchanged; HALT sets a sticky halted
// bit and execution continues.
module z80_register_alu_executor_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  z80alu_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output z80alu_pkg::out_item_t  out_item
);

  // architectural state
  z80alu_pkg::regfile_t  rf_r, rf_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic                  halt_r, halt_nxt;

  // output register and skid stage
  z80alu_pkg::out_item_t out_item_r, skid_item_r, res;
  logic                  out_valid_r, skid_valid_r;

  logic in_fire, out_fire;

  // decoded fields
  logic [1:0] op;
  logic [2:0] fy, fz;
  logic [7:0] a, vz, vy;

  // datapath terms
  logic [8:0] sum9, diff9;
  logic [4:0] hsum5;
  logic       hborrow, add_ovf, sub_ovf;
  logic [7:0] sub_flags, r_and, r_xor, r_or, inc_v, dec_v;

  // execution results
  logic        dv, wv;
  logic [2:0]  di;
  logic [7:0]  dval, wdata;
  logic [15:0] waddr;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid_r & out_ready;
  assign in_ready = ~skid_valid_r;

  assign op = in_item.opcode[7:6];
  assign fy = in_item.opcode[5:3];
  assign fz = in_item.opcode[2:0];
  assign a  = rf_r.a;
  assign vz = z80alu_pkg::rf_read(rf_r, fz);
  assign vy = z80alu_pkg::rf_read(rf_r, fy);

  // shared adder, subtractor and logic terms
  assign sum9    = {1'b0, a} + {1'b0, vz};
  assign diff9   = {1'b0, a} - {1'b0, vz};
  assign hsum5   = {1'b0, a[3:0]} + {1'b0, vz[3:0]};
  assign hborrow = (a[3:0] < vz[3:0]);
  assign add_ovf = (a[7] ^ sum9[7]) & (vz[7] ^ sum9[7]);
  assign sub_ovf = (a[7] ^ vz[7]) & (a[7] ^ diff9[7]);
  assign r_and   = a & vz;
  assign r_xor   = a ^ vz;
  assign r_or    = a | vz;
  assign inc_v   = vy + 8'd1;
  assign dec_v   = vy - 8'd1;
  assign sub_flags = z80alu_pkg::mk_flags(diff9[7:0], hborrow, sub_ovf, 1'b1, diff9[8]);

  // instruction execution
  always_comb begin
    dv        = 1'b0;
    di        = 3'd0;
    dval      = 8'h00;
    wv        = 1'b0;
    waddr     = 16'h0000;
    wdata     = 8'h00;
    flags_nxt = flags_r;
    halt_nxt  = halt_r;
    case (op)
      z80alu_pkg::GRP_ALU: begin
        if (fz != z80alu_pkg::REG_HL_MEM) begin
          case (fy)
            z80alu_pkg::ALU_ADD: begin
              dv        = 1'b1;
              dval      = sum9[7:0];
              flags_nxt = z80alu_pkg::mk_flags(sum9[7:0], hsum5[4], add_ovf, 1'b0, sum9[8]);
            end
            z80alu_pkg::ALU_SUB: begin
              dv        = 1'b1;
              dval      = diff9[7:0];
              flags_nxt = sub_flags;
            end
            z80alu_pkg::ALU_AND: begin
              dv        = 1'b1;
              dval      = r_and;
              flags_nxt = z80alu_pkg::mk_flags(r_and, 1'b1, ~(^r_and), 1'b0, 1'b0);
            end
            z80alu_pkg::ALU_XOR: begin
              dv        = 1'b1;
              dval      = r_xor;
              flags_nxt = z80alu_pkg::mk_flags(r_xor, 1'b0, ~(^r_xor), 1'b0, 1'b0);
            end
            z80alu_pkg::ALU_OR: begin
              dv        = 1'b1;
              dval      = r_or;
              flags_nxt = z80alu_pkg::mk_flags(r_or, 1'b0, ~(^r_or), 1'b0, 1'b0);
            end
            z80alu_pkg::ALU_CP: begin
              flags_nxt = sub_flags;
            end
            default: begin
              // adc and sbc are not executed
            end
          endcase
          if (dv) begin
            di = z80alu_pkg::REG_A;
          end
        end
      end
      z80alu_pkg::GRP_LOAD: begin
        if (fy == z80alu_pkg::REG_HL_MEM && fz == z80alu_pkg::REG_HL_MEM) begin
          halt_nxt = 1'b1;
        end else if (fy == z80alu_pkg::REG_HL_MEM) begin
          wv    = 1'b1;
          waddr = {rf_r.h, rf_r.l};
          wdata = vz;
        end else if (fz != z80alu_pkg::REG_HL_MEM) begin
          dv   = 1'b1;
          di   = fy;
          dval = vz;
        end
      end
      z80alu_pkg::GRP_MISC: begin
        if (fy != z80alu_pkg::REG_HL_MEM) begin
          case (fz)
            z80alu_pkg::Z_IMM: begin
              dv   = 1'b1;
              di   = fy;
              dval = in_item.immediate;
            end
            z80alu_pkg::Z_INC: begin
              dv        = 1'b1;
              di        = fy;
              dval      = inc_v;
              flags_nxt = z80alu_pkg::mk_flags(inc_v, (vy[3:0] == 4'hF),
                                               (vy == z80alu_pkg::INC_OVF_VAL), 1'b0,
                                               flags_r[z80alu_pkg::FLAG_C]);
            end
            z80alu_pkg::Z_DEC: begin
              dv        = 1'b1;
              di        = fy;
              dval      = dec_v;
              flags_nxt = z80alu_pkg::mk_flags(dec_v, (vy[3:0] == 4'h0),
                                               (vy == z80alu_pkg::DEC_OVF_VAL), 1'b1,
                                               flags_r[z80alu_pkg::FLAG_C]);
            end
            default: begin
              // other misc opcodes are not executed
            end
          endcase
        end
      end
      default: begin
        // jumps, calls and stack operations are not executed
      end
    endcase
  end

  // register file write-back
  always_comb begin
    rf_nxt = rf_r;
    if (dv) begin
      case (di)
        z80alu_pkg::REG_B: rf_nxt.b = dval;
        z80alu_pkg::REG_C: rf_nxt.c = dval;
        z80alu_pkg::REG_D: rf_nxt.d = dval;
        z80alu_pkg::REG_E: rf_nxt.e = dval;
        z80alu_pkg::REG_H: rf_nxt.h = dval;
        z80alu_pkg::REG_L: rf_nxt.l = dval;
        z80alu_pkg::REG_A: rf_nxt.a = dval;
        default: ;
      endcase
    end
  end

  // result item of the current input
  always_comb begin
    res.accumulator   = rf_nxt.a;
    res.flags         = flags_nxt;
    res.dest_valid    = dv;
    res.dest_index    = di;
    res.dest_value    = dval;
    res.write_valid   = wv;
    res.write_address = waddr;
    res.write_data    = wdata;
    res.halted        = halt_nxt;
  end

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r    <= '0;
      flags_r <= 8'h00;
      halt_r  <= 1'b0;
    end else if (in_fire) begin
      rf_r    <= rf_nxt;
      flags_r <= flags_nxt;
      halt_r  <= halt_nxt;
    end
  end

  // output register and skid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_item_r <= skid_item_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_item_r <= res;
      end else begin
        out_item_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `include "z80_register_alu_executor_unit_assert.svh"

  `Z80ALU_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `Z80ALU_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt mark cleared without reset")
  `Z80ALU_ASSERT_NOW(a_one_target, out_valid_r, !(out_item_r.dest_valid && out_item_r.write_valid), "register and memory write in one item")
  `Z80ALU_ASSERT_NOW(a_flag_gaps, out_valid_r, (out_item_r.flags[5] == 1'b0) && (out_item_r.flags[3] == 1'b0), "unused flag bits set")

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the z80 register alu executor
`timescale 1ns / 1ps

module tb_top;
  import z80alu_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_TARGET = 1750;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // shadow machine state, indexed by register code; the (hl) code is unused
  logic [7:0] reg_shadow [8];
  logic [7:0] flag_shadow;
  logic       halt_shadow;

  out_item_t  expected_results [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       no_idle = 1'b0;

  z80_register_alu_executor_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 31);
    end
  end

  // flag byte from a result and the computed condition bits
  function automatic logic [7:0] flag_byte(logic [7:0] r, logic h, logic pv, logic n, logic c);
    return {r[7], (r == 8'h00), 1'b0, h, 1'b0, pv, n, c};
  endfunction

  // flags of a - v, shared by sub and compare
  function automatic logic [7:0] sub_flags_of(logic [7:0] a, logic [7:0] v);
    logic [7:0] r;
    r = a - v;
    return flag_byte(r, a[3:0] < v[3:0], (a[7] != v[7]) && (a[7] != r[7]), 1'b1, a < v);
  endfunction

  // execute one instruction on the shadow state and return its result item
  function automatic out_item_t execute_instr(in_item_t item);
    out_item_t  res;
    op_grp_t    grp;
    logic [2:0] y;
    logic [2:0] z;
    logic [7:0] acc;
    logic [7:0] v;
    logic [7:0] r;
    logic [7:0] old;
    logic [8:0] sum;
    res = '0;
    grp = op_grp_t'(item.opcode[7:6]);
    y = item.opcode[5:3];
    z = item.opcode[2:0];
    acc = reg_shadow[REG_A];
    case (grp)
      GRP_ALU: begin
        if (z != REG_HL_MEM) begin
          v = reg_shadow[z];
          case (y)
            ALU_ADD: begin
              sum = {1'b0, acc} + {1'b0, v};
              r = sum[7:0];
              flag_shadow = flag_byte(r, ({1'b0, acc[3:0]} + {1'b0, v[3:0]}) > 5'd15,
                                      (acc[7] == v[7]) && (r[7] != acc[7]), 1'b0, sum[8]);
              res.dest_valid = 1'b1;
              res.dest_value = r;
            end
            ALU_SUB: begin
              flag_shadow = sub_flags_of(acc, v);
              res.dest_valid = 1'b1;
              res.dest_value = acc - v;
            end
            ALU_AND: begin
              r = acc & v;
              flag_shadow = flag_byte(r, 1'b1, ~^r, 1'b0, 1'b0);
              res.dest_valid = 1'b1;
              res.dest_value = r;
            end
            ALU_XOR: begin
              r = acc ^ v;
              flag_shadow = flag_byte(r, 1'b0, ~^r, 1'b0, 1'b0);
              res.dest_valid = 1'b1;
              res.dest_value = r;
            end
            ALU_OR: begin
              r = acc | v;
              flag_shadow = flag_byte(r, 1'b0, ~^r, 1'b0, 1'b0);
              res.dest_valid = 1'b1;
              res.dest_value = r;
            end
            ALU_CP: begin
              flag_shadow = sub_flags_of(acc, v);
            end
            default: ;
          endcase
          if (res.dest_valid) res.dest_index = REG_A;
        end
      end
      GRP_LOAD: begin
        if (y == REG_HL_MEM && z == REG_HL_MEM) begin
          halt_shadow = 1'b1;
        end else if (y == REG_HL_MEM) begin
          res.write_valid = 1'b1;
          res.write_address = {reg_shadow[REG_H], reg_shadow[REG_L]};
          res.write_data = reg_shadow[z];
        end else if (z != REG_HL_MEM) begin
          res.dest_valid = 1'b1;
          res.dest_index = y;
          res.dest_value = reg_shadow[z];
        end
      end
      GRP_MISC: begin
        if (y != REG_HL_MEM) begin
          old = reg_shadow[y];
          case (z)
            Z_IMM: begin
              res.dest_valid = 1'b1;
              res.dest_value = item.immediate;
            end
            Z_INC: begin
              r = old + 8'd1;
              flag_shadow = flag_byte(r, old[3:0] == 4'hF, old == INC_OVF_VAL, 1'b0,
                                      flag_shadow[FLAG_C]);
              res.dest_valid = 1'b1;
              res.dest_value = r;
            end
            Z_DEC: begin
              r = old - 8'd1;
              flag_shadow = flag_byte(r, old[3:0] == 4'h0, old == DEC_OVF_VAL, 1'b1,
                                      flag_shadow[FLAG_C]);
              res.dest_valid = 1'b1;
              res.dest_value = r;
            end
            default: ;
          endcase
          if (res.dest_valid) res.dest_index = y;
        end
      end
      default: ;
    endcase
    // register write back
    if (res.dest_valid) begin
      reg_shadow[res.dest_index] = res.dest_value;
    end
    res.accumulator = reg_shadow[REG_A];
    res.flags = flag_shadow;
    res.halted = halt_shadow;
    return res;
  endfunction

  // send one instruction item, with random idle cycles ahead of it
  task automatic send_instr(input logic [7:0] opc, input logic [7:0] imm);
    in_item_t item;
    item.opcode = opc;
    item.immediate = imm;
    while (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(execute_instr(item));
  endtask

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_item);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("accumulator", 16'(want.accumulator), 16'(out_item.accumulator));
        check_field("flags", 16'(want.flags), 16'(out_item.flags));
        check_field("dest_valid", 16'(want.dest_valid), 16'(out_item.dest_valid));
        check_field("dest_index", 16'(want.dest_index), 16'(out_item.dest_index));
        check_field("dest_value", 16'(want.dest_value), 16'(out_item.dest_value));
        check_field("write_valid", 16'(want.write_valid), 16'(out_item.write_valid));
        check_field("write_address", want.write_address, out_item.write_address);
        check_field("write_data", 16'(want.write_data), 16'(out_item.write_data));
        check_field("halted", 16'(want.halted), 16'(out_item.halted));
      end
    end
  end

  // immediate loads with extreme values
  task automatic test_load_immediate;
    send_instr(8'h3E, 8'hFF);
    send_instr(8'h06, 8'h00);
    send_instr(8'h0E, 8'h01);
    send_instr(8'h16, 8'h80);
    send_instr(8'h1E, 8'h7F);
  endtask

  // every alu operation but sbc, carry and borrow, adc as a no-op
  task automatic test_alu_ops;
    send_instr(8'h80, 8'h00);
    send_instr(8'h81, 8'h00);
    send_instr(8'h91, 8'h00);
    send_instr(8'hA2, 8'h00);
    send_instr(8'hAB, 8'h00);
    send_instr(8'hB3, 8'h00);
    send_instr(8'hBB, 8'h00);
    send_instr(8'h8A, 8'h00);
  endtask

  // inc and dec at the overflow and wrap boundaries
  task automatic test_inc_dec;
    send_instr(8'h1C, 8'h00);
    send_instr(8'h15, 8'h00);
    send_instr(8'h05, 8'h00);
  endtask

  // memory write, (hl) operand forms, register copy and an uncovered opcode
  task automatic test_hl_forms;
    send_instr(8'h77, 8'h00);
    send_instr(8'h36, 8'h5A);
    send_instr(8'h34, 8'h00);
    send_instr(8'h86, 8'h00);
    send_instr(8'h7E, 8'h00);
    send_instr(8'h41, 8'h00);
    send_instr(8'hC3, 8'hFF);
  endtask

  // halt is sticky and execution goes on
  task automatic test_halt;
    send_instr(8'h76, 8'h00);
    send_instr(8'h3C, 8'h00);
  endtask

  // mostly covered instructions with random operands, some random bytes
  task automatic test_random_stream;
    logic [7:0] opc;
    logic [7:0] imm;
    logic [2:0] ry;
    logic [2:0] rz;
    int         sent;
    sent = 0;
    while (sent < RANDOM_TARGET) begin
      // pick register codes that avoid the (hl) form
      ry = 3'($urandom_range(6));
      if (ry == REG_HL_MEM) ry = REG_A;
      rz = 3'($urandom_range(6));
      if (rz == REG_HL_MEM) rz = REG_A;
      case ($urandom_range(9))
        0, 1:    opc = {GRP_MISC, ry, Z_IMM};
        2, 3, 4: opc = {GRP_ALU, 3'($urandom_range(7)), rz};
        5:       opc = {GRP_MISC, ry, (($urandom_range(1) == 0) ? Z_INC : Z_DEC)};
        6:       opc = {GRP_LOAD, 3'($urandom_range(7)), rz};
        default: opc = 8'($urandom_range(255));
      endcase
      // bias the immediate toward boundary values
      case ($urandom_range(7))
        0:       imm = 8'h00;
        1:       imm = 8'hFF;
        2:       imm = 8'h7F;
        3:       imm = 8'h80;
        4:       imm = 8'h0F;
        default: imm = 8'($urandom_range(255));
      endcase
      // a stretch with no idling on either side
      no_idle = (sent >= 600 && sent < 900);
      send_instr(opc, imm);
      sent++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (reg_shadow[i]) reg_shadow[i] = 8'h00;
    flag_shadow = 8'h00;
    halt_shadow = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_immediate();
    test_alu_ops();
    test_inc_dec();
    test_hl_forms();
    test_halt();
    test_random_stream();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/z80alu_pkg.sv
rtl/z80_register_alu_executor_unit.sv
tb/sv/tb_top.sv
